// ----- hdl/sapq_pkg.sv -----
// sapq_pkg: shared types and constants for the slot-array priority queue.
// Holds the request/response words, the result codes, the controller state
// type and the command/status bundles between controller and datapath.
`default_nettype none

package sapq_pkg;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_REMOVED  = 2'd2,
    STAT_EMPTY    = 2'd3
  } rsp_status_t;

  typedef struct packed {
    op_t                       operation;
    logic [PRIO_W-1:0]         priority_req;
    logic signed [DATA_W-1:0]  payload;
  } req_word_t;

  typedef struct packed {
    rsp_status_t               status;
    logic [PRIO_W-1:0]         out_priority;
    logic signed [DATA_W-1:0]  out_payload;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_REM_SCAN,
    ST_REM_WAIT,
    ST_REM_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic        latch;      // capture the request word
    logic        ins_fill;   // write at the fill pointer, advance it
    logic        ins_scan;   // write at the scan index
    logic        scan_rst;   // restart the scan and the running minimum
    logic        scan_adv;   // step the scan index
    logic        rem_issue;  // read the slot at the scan index for compare
    logic        rem_free;   // free the best slot
    logic        respond;    // load the result register
    rsp_status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic fill_sat;
    logic scan_free;
    logic scan_last;
    logic best_found;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/sapq_ctrl.sv -----
// sapq_ctrl: sequencer for insert and remove operations.
// Depends on sapq_pkg; drives dp_cmd_t, reads dp_stat_t from sapq_dp.
`default_nettype none

module sapq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sapq_pkg::op_t     operation,
  input  wire sapq_pkg::dp_stat_t stat,
  output sapq_pkg::dp_cmd_t      cmd,
  output logic                   busy
);
  import sapq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = STAT_INSERTED;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          if (operation == OP_INSERT) begin
            if (stat.full) begin
              cmd.respond = 1'b1;
              cmd.status  = STAT_FULL;
            end else if (!stat.fill_sat) begin
              cmd.ins_fill = 1'b1;
              cmd.respond  = 1'b1;
              cmd.status   = STAT_INSERTED;
            end else begin
              cmd.scan_rst = 1'b1;
              state_next   = ST_INS_SCAN;
            end
          end else begin
            if (stat.empty) begin
              cmd.respond = 1'b1;
              cmd.status  = STAT_EMPTY;
            end else begin
              cmd.scan_rst = 1'b1;
              state_next   = ST_REM_SCAN;
            end
          end
        end
      end
      ST_INS_SCAN: begin
        if (stat.scan_free) begin
          cmd.ins_scan = 1'b1;
          cmd.respond  = 1'b1;
          cmd.status   = STAT_INSERTED;
          state_next   = ST_IDLE;
        end else if (stat.scan_last) begin
          cmd.respond = 1'b1;
          cmd.status  = STAT_FULL;
          state_next  = ST_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_REM_SCAN: begin
        cmd.rem_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_REM_WAIT;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_REM_WAIT: begin
        // last slot is compared at this edge
        state_next = ST_REM_DONE;
      end
      ST_REM_DONE: begin
        cmd.respond = 1'b1;
        if (stat.best_found) begin
          cmd.rem_free = 1'b1;
          cmd.status   = STAT_REMOVED;
        end else begin
          cmd.status = STAT_EMPTY;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sapq_dp.sv -----
// sapq_dp: slot storage, counters, scan index, running minimum and result register.
// Depends on sapq_pkg; steered by sapq_ctrl through dp_cmd_t.
`default_nettype none

module sapq_dp #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sapq_pkg::req_word_t req,
  input  wire sapq_pkg::dp_cmd_t   cmd,
  output sapq_pkg::dp_stat_t       stat,
  output sapq_pkg::rsp_word_t      rsp,
  output logic                     done
);
  import sapq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;

  // slot storage: valid bits in flops, priority and data in a memory
  logic [DEPTH-1:0]  slot_valid;
  logic [PW-1:0]     slot_priority [DEPTH];
  logic [DATA_W-1:0] slot_payload  [DEPTH];

  logic [CW-1:0]     fill_pointer;
  logic [CW-1:0]     entry_count;
  logic [AW-1:0]     scan_idx;

  req_word_t         held;
  logic [PW-1:0]     wr_prio;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  logic [PW-1:0]     rd_prio;
  logic [DATA_W-1:0] rd_data;
  logic              pipe_v;
  logic              pipe_vbit;
  logic [AW-1:0]     pipe_idx;

  logic              best_found;
  logic [PW-1:0]     best_prio;
  logic [DATA_W-1:0] best_data;
  logic [AW-1:0]     best_idx;
  logic              better;

  assign wr_en   = cmd.ins_fill | cmd.ins_scan;
  assign wr_addr = cmd.ins_fill ? fill_pointer[AW-1:0] : scan_idx;
  assign wr_prio = cmd.ins_fill ? req.priority_req[PW-1:0] : held.priority_req[PW-1:0];
  assign wr_data = cmd.ins_fill ? req.payload : held.payload;

  assign stat.full       = (entry_count == CW'(DEPTH));
  assign stat.empty      = (entry_count == '0);
  assign stat.fill_sat   = (fill_pointer == CW'(DEPTH));
  assign stat.scan_free  = !slot_valid[scan_idx];
  assign stat.scan_last  = (scan_idx == AW'(DEPTH - 1));
  assign stat.best_found = best_found;

  assign better = pipe_v && pipe_vbit && (!best_found || (rd_prio < best_prio));

  // memory: one write port, one registered read port at the scan index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_priority[wr_addr] <= wr_prio;
      slot_payload[wr_addr]  <= wr_data;
    end
    rd_prio <= slot_priority[scan_idx];
    rd_data <= slot_payload[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      held <= req;
    end
    pipe_vbit <= slot_valid[scan_idx];
    pipe_idx  <= scan_idx;
    if (better) begin
      best_prio <= rd_prio;
      best_data <= rd_data;
      best_idx  <= pipe_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      fill_pointer <= '0;
      entry_count  <= '0;
      scan_idx     <= '0;
      pipe_v       <= 1'b0;
      best_found   <= 1'b0;
    end else begin
      pipe_v <= cmd.rem_issue;
      if (cmd.scan_rst) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else begin
        if (cmd.scan_adv) begin
          scan_idx <= scan_idx + AW'(1);
        end
        if (better) begin
          best_found <= 1'b1;
        end
      end
      if (wr_en) begin
        slot_valid[wr_addr] <= 1'b1;
        entry_count         <= entry_count + CW'(1);
      end
      if (cmd.ins_fill) begin
        fill_pointer <= fill_pointer + CW'(1);
      end
      if (cmd.rem_free) begin
        slot_valid[best_idx] <= 1'b0;
        entry_count          <= entry_count - CW'(1);
      end
    end
  end

  // result register: one strobe per word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      rsp.status <= cmd.status;
      if (cmd.status == STAT_REMOVED) begin
        rsp.out_priority <= PRIO_W'(best_prio);
        rsp.out_payload  <= best_data;
      end else begin
        rsp.out_priority <= '0;
        rsp.out_payload  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/slot_array_priority_queue.sv -----
// Channel   Ports               Handshake
// request   req (req_word_t)    accepted on a rising edge with start high, busy low
// result    rsp (rsp_word_t)    valid for one cycle while done is high
//
// Insert below the fill limit, insert when full and remove when empty: done
// in the cycle after acceptance. Insert once the fill pointer has saturated:
// a free-slot search from slot 0 up to the first free slot, one valid bit a
// cycle. Remove: a scan of every slot, one slot a cycle through the memory read port.
// Synchronous reset empties the queue at once. The receiver cannot stall.
// Top level: sapq_ctrl and sapq_dp, types from sapq_pkg.
`default_nettype none

module slot_array_priority_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire sapq_pkg::req_word_t req,
  output logic                     done,
  output sapq_pkg::rsp_word_t      rsp
);
  import sapq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (req.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  sapq_dp #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp),
    .done (done)
  );

endmodule

`default_nettype wire

// ----- hdl/sapq_chk.sv -----
// sapq_chk: port-level checks on the slot-array priority queue, bound to the top.
// Depends on sapq_pkg for the result codes.
`default_nettype none

module sapq_chk (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire sapq_pkg::rsp_word_t  rsp
);
  import sapq_pkg::*;

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("queue not idle after reset");

  // an accepted word either answers next cycle or holds the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither answered nor in progress");

  // leaving a multi-cycle operation always delivers its word
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("operation ended without a result");

  // only a removal carries entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_REMOVED) |-> (rsp.out_priority == '0 && rsp.out_payload == '0))
    else $error("non-removal result carries entry fields");

endmodule

bind slot_array_priority_queue sapq_chk u_sapq_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

// ----- tb/sv/sapq_checker.sv -----
// sapq_checker: watches the request and result channels of the slot-array
// priority queue, keeps its own copy of the slots and checks every result word.
// Depends on sapq_pkg for the word types and the result codes.
module sapq_checker
  import sapq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  req_word_t req,
  input  logic      done,
  input  rsp_word_t rsp,
  output int        fail_count,
  output int        outstanding,
  output int        inserted_seen,
  output int        full_seen,
  output int        removed_seen,
  output int        empty_seen
);

  localparam logic [31:0] PRIO_MASK =
    (PRIO_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PRIO_BITS) - 32'd1);

  logic              slot_used [DEPTH];
  logic [PRIO_W-1:0] slot_prio [DEPTH];
  logic [DATA_W-1:0] slot_data [DEPTH];
  int unsigned       fill_ptr;
  int unsigned       occupancy;
  rsp_word_t         expected_rsp_q[$];
  int                mismatches = 0;
  int                status_count [4] = '{default: 0};

  // Apply one request word to the slot copy and return the result word it earns.
  function automatic rsp_word_t apply_request(req_word_t w);
    rsp_word_t r;
    int        slot;
    r    = '0;
    slot = -1;
    if (w.operation == OP_INSERT) begin
      r.status = STAT_FULL;
      if (occupancy < DEPTH) begin
        if (fill_ptr < DEPTH) begin
          slot = fill_ptr;
          fill_ptr++;
        end else begin
          // lowest free slot once the fill pointer has saturated
          for (int i = DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
        end
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          slot_prio[slot] = w.priority_req & PRIO_MASK[PRIO_W-1:0];
          slot_data[slot] = w.payload;
          occupancy++;
          r.status = STAT_INSERTED;
        end
      end
    end else begin
      r.status = STAT_EMPTY;
      // strict less-than keeps the lowest index on equal priorities
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i] && (slot < 0 || slot_prio[i] < slot_prio[slot])) slot = i;
      if (slot >= 0) begin
        r.status        = STAT_REMOVED;
        r.out_priority  = slot_prio[slot];
        r.out_payload   = slot_data[slot];
        slot_used[slot] = 1'b0;
        occupancy--;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_word_t exp_w;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_prio[i] = '0;
        slot_data[i] = '0;
      end
      fill_ptr  = 0;
      occupancy = 0;
      expected_rsp_q.delete();
    end else begin
      // retire the result word before taking a new request on the same edge
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing outstanding: status %0d prio %0d data %h",
                     $time, rsp.status, rsp.out_priority, rsp.out_payload);
        end else begin
          exp_w = expected_rsp_q.pop_front();
          if (rsp.status !== exp_w.status || rsp.out_priority !== exp_w.out_priority ||
              rsp.out_payload !== exp_w.out_payload) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: expected status %0d prio %0d data %h, got %0d %0d %h",
                       $time, exp_w.status, exp_w.out_priority, exp_w.out_payload,
                       rsp.status, rsp.out_priority, rsp.out_payload);
          end
        end
      end
      if (start && !busy) begin
        exp_w = apply_request(req);
        expected_rsp_q.push_back(exp_w);
        status_count[exp_w.status]++;
      end
    end
    fail_count    <= mismatches;
    outstanding   <= expected_rsp_q.size();
    inserted_seen <= status_count[STAT_INSERTED];
    full_seen     <= status_count[STAT_FULL];
    removed_seen  <= status_count[STAT_REMOVED];
    empty_seen    <= status_count[STAT_EMPTY];
  end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: top of the slot-array priority queue test. Drives insert and remove
// words in bursts and gives the verdict; checking lives in sapq_checker.
// Depends on sapq_pkg, slot_array_priority_queue and sapq_checker.
module testbench;
  import sapq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PRIO_BITS    = 8;
  localparam int          DIRECTED     = 22;
  localparam int          RANDOM_ITEMS = 480;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  req_word_t req   = '0;
  logic      busy;
  logic      done;
  rsp_word_t rsp;

  int fail_count;
  int outstanding;
  int inserted_seen;
  int full_seen;
  int removed_seen;
  int empty_seen;

  int words_sent   = 0;
  int inserts_sent = 0;
  int removes_sent = 0;
  int burst_left   = 6;
  int drain_pauses = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slot_array_priority_queue #(.DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  sapq_checker #(.DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .inserted_seen (inserted_seen),
    .full_seen     (full_seen),
    .removed_seen  (removed_seen),
    .empty_seen    (empty_seen)
  );

  // Hold the word until it is taken; start stays high into the next word
  // unless the burst runs out.
  task automatic push_word(input op_t op, input logic [PRIO_W-1:0] prio,
                           input logic [DATA_W-1:0] data);
    req_word_t w;
    int        gap;
    w.operation    = op;
    w.priority_req = prio;
    w.payload      = data;
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (op == OP_INSERT) inserts_sent++;
    else removes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // narrow priorities crowd the slots with ties
  task automatic push_random(input op_t op, input logic narrow);
    logic [PRIO_W-1:0] prio;
    prio = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom_range(0, 255));
    push_word(op, prio, $urandom);
  endtask

  task automatic wait_for_drain();
    if (start) start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // let a scan still in flight settle
    repeat (DEPTH + 4) @(posedge clk);
    drain_pauses++;
  endtask

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int   kind;
    int   len;
    int   bias;
    logic narrow;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // remove on an empty queue, then fill through the fill pointer
    push_word(OP_REMOVE, 8'd0, 32'd0);
    push_word(OP_INSERT, 8'd255, 32'h7FFF_FFFF);
    push_word(OP_INSERT, 8'd0, 32'h8000_0000);
    push_word(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
    push_word(OP_INSERT, 8'hAA, 32'h5555_5555);
    push_word(OP_INSERT, 8'h55, 32'hAAAA_AAAA);
    for (int i = 0; i < 11; i++) push_word(OP_INSERT, PRIO_W'(100 + i), DATA_W'(i));
    // full rejection, tie on priority zero, reuse of a freed slot
    push_word(OP_INSERT, 8'd1, 32'h0000_0001);
    push_word(OP_REMOVE, 8'd0, 32'd0);
    push_word(OP_REMOVE, 8'd0, 32'd0);
    push_word(OP_INSERT, 8'd0, 32'h0000_1234);
    push_word(OP_REMOVE, 8'd0, 32'd0);
    wait_for_drain();

    while (words_sent < DIRECTED + RANDOM_ITEMS) begin
      kind   = $urandom_range(0, 3);
      narrow = ($urandom_range(0, 2) == 0);
      case (kind)
        0: repeat (DEPTH + $urandom_range(1, 3)) push_random(OP_INSERT, narrow);
        1: repeat (DEPTH + $urandom_range(1, 3)) push_random(OP_REMOVE, narrow);
        default: begin
          len  = $urandom_range(8, 40);
          bias = $urandom_range(25, 75);
          repeat (len)
            push_random(($urandom_range(1, 100) <= bias) ? OP_INSERT : OP_REMOVE, narrow);
        end
      endcase
      if ($urandom_range(0, 5) == 0) wait_for_drain();
    end
    wait_for_drain();

    $display("Sent %0d words: %0d inserts and %0d removes, %0d pauses to an empty pipeline.",
             words_sent, inserts_sent, removes_sent, drain_pauses);
    $display("Outcomes: %0d stored, %0d refused as full, %0d removed, %0d on an empty queue.",
             inserted_seen, full_seen, removed_seen, empty_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sapq_pkg.sv
hdl/sapq_ctrl.sv
hdl/sapq_dp.sv
hdl/slot_array_priority_queue.sv
hdl/sapq_chk.sv
tb/sv/sapq_checker.sv
tb/sv/testbench.sv
